/* rtl/obfd_pkg.sv */
// shared types and constants for the optimal bid from win distribution block
// no dependencies; imported by the controller, datapath and top level
package obfd_pkg;

	localparam int MAX_BINS = 1024;
	localparam int IDX_W    = $clog2(MAX_BINS);
	localparam int CNT_W    = IDX_W + 1;
	localparam int PROB_W   = 16;
	localparam int VAL_W    = 24;
	localparam int MULT_W   = 16;
	localparam int FRAC_W   = 12;
	localparam int SUM_W    = 26;
	localparam int BID_W    = IDX_W + FRAC_W;
	localparam int PRF_W    = 39;
	localparam int BIN_W    = 10;
	localparam int SPLIT_W  = SUM_W / 2;
	localparam int PP_W     = VAL_W + SPLIT_W;
	localparam int BEST_W   = VAL_W + SUM_W;
	localparam int FPROD_W  = FRAC_W + SUM_W;
	localparam int DIFF_W   = VAL_W + 4 + 1;
	localparam int WPROD_W  = DIFF_W + SUM_W + 1;
	localparam int PRF_SHIFT = 20;

	localparam logic [MULT_W-1:0] MULT_RESET = MULT_W'(4096);
	localparam logic [SUM_W-1:0]  SUM_MAX    = {SUM_W{1'b1}};

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_LO,
		S_MUL_HI,
		S_CMP,
		S_BID,
		S_RD0,
		S_RD1,
		S_INTERP,
		S_SUM,
		S_PROF,
		S_EMIT
	} obfd_state_t;

	typedef enum logic [1:0] {
		LK_ZERO,
		LK_SINGLE,
		LK_INTERP
	} obfd_lookup_t;

	typedef struct packed {
		logic load;
		logic mul_lo;
		logic mul_hi;
		logic cmp;
		logic bid;
		logic rd0;
		logic rd1;
		logic interp;
		logic sum;
		logic prof;
		logic emit;
	} obfd_cmd_t;

	typedef struct packed {
		logic last;
		logic out_free;
	} obfd_status_t;

endpackage

/* rtl/optimal_bid_from_win_distribution_unit.sv */
// Optimal bid from a streamed win distribution, built from a controller and a
// datapath. Channels: bins enter on in_valid/in_ready (prob_bin, bid_value,
// last_bin), results leave on out_valid/out_ready, and strategy_multiplier is
// written on cfg_valid/cfg_ready, which is always ready.
// Each bin passes through the accept cycle, two partial products of the
// 24 x 26 bit profit multiply and the argmax compare. After a bin with
// last_bin set, the result is shown on out_valid once bid scaling, two reads
// on the read port of the prefix store, the interpolation multiply, the sum
// and the profit multiply are done. The store holds one entry per bin; the
// second read may hit an entry not written in this run, whose value is unused.
// One result sits in the output register; the unit goes on taking bins of the
// next run while it waits. If a second result is ready before the first is
// taken, the unit holds it and accepts no bins until out_ready frees the register.
// Reset is asynchronous: it clears the run state, drops out_valid and sets the
// multiplier to one (4096 in Q4.12). Bins past the store depth are dropped and
// reported in too_many_bins.
module optimal_bid_from_win_distribution_unit
	import obfd_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [PROB_W-1:0]       prob_bin,
	input  logic [VAL_W-1:0]        bid_value,
	input  logic                    last_bin,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [MULT_W-1:0]       strategy_multiplier,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [BID_W-1:0]        shaded_bid,
	output logic [SUM_W-1:0]        win_prob_at_bid,
	output logic signed [PRF_W-1:0] profit_est,
	output logic [BIN_W-1:0]        chosen_bin,
	output logic                    too_many_bins
);

	obfd_cmd_t    cmd;
	obfd_status_t status;

	assign cfg_ready = 1'b1;

	obfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	obfd_datapath u_datapath (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.status              (status),
		.prob_bin            (prob_bin),
		.bid_value           (bid_value),
		.last_bin            (last_bin),
		.cfg_valid           (cfg_valid),
		.strategy_multiplier (strategy_multiplier),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.shaded_bid          (shaded_bid),
		.win_prob_at_bid     (win_prob_at_bid),
		.profit_est          (profit_est),
		.chosen_bin          (chosen_bin),
		.too_many_bins       (too_many_bins)
	);

endmodule

/* rtl/obfd_ctrl.sv */
// sequencer for the bid unit: walks each bin through the profit compare and,
// after the last bin, through bid scaling, table lookup and output; uses obfd_pkg
module obfd_ctrl
	import obfd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  obfd_status_t status,
	output obfd_cmd_t    cmd
);

	obfd_state_t state_q;
	obfd_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_MUL_LO;
				end
			end
			S_MUL_LO: begin
				cmd.mul_lo = 1'b1;
				state_d    = S_MUL_HI;
			end
			S_MUL_HI: begin
				cmd.mul_hi = 1'b1;
				state_d    = S_CMP;
			end
			S_CMP: begin
				cmd.cmp = 1'b1;
				state_d = status.last ? S_BID : S_IDLE;
			end
			S_BID: begin
				cmd.bid = 1'b1;
				state_d = S_RD0;
			end
			S_RD0: begin
				cmd.rd0 = 1'b1;
				state_d = S_RD1;
			end
			S_RD1: begin
				cmd.rd1 = 1'b1;
				state_d = S_INTERP;
			end
			S_INTERP: begin
				cmd.interp = 1'b1;
				state_d    = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = S_PROF;
			end
			S_PROF: begin
				cmd.prof = 1'b1;
				state_d  = S_EMIT;
			end
			S_EMIT: begin
				// hold here until the output register can take the result
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command in a cycle");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.out_free)
		else $error("result loaded over a pending transaction");

	a_bin_return: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.cmp && !status.last) |=> in_ready)
		else $error("not ready for the next bin after a middle bin");
`endif

endmodule

/* rtl/obfd_datapath.sv */
// datapath of the bid unit: prefix store, running sum, profit argmax,
// bid scaling, interpolated lookup, profit product and output register; uses obfd_pkg
module obfd_datapath
	import obfd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  obfd_cmd_t           cmd,
	output obfd_status_t        status,
	input  logic [PROB_W-1:0]   prob_bin,
	input  logic [VAL_W-1:0]    bid_value,
	input  logic                last_bin,
	input  logic                cfg_valid,
	input  logic [MULT_W-1:0]   strategy_multiplier,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [BID_W-1:0]    shaded_bid,
	output logic [SUM_W-1:0]    win_prob_at_bid,
	output logic signed [PRF_W-1:0] profit_est,
	output logic [BIN_W-1:0]    chosen_bin,
	output logic                too_many_bins
);

	logic [SUM_W-1:0]  prefix_mem [MAX_BINS];
	logic [SUM_W-1:0]  rdata_q;
	logic [IDX_W-1:0]  rd_addr;

	logic [MULT_W-1:0] mult_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [VAL_W-1:0]  held_q;
	logic              ovf_q;
	logic [BEST_W-1:0] best_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic              last_q;
	logic              bin_ok_q;
	logic              first_q;
	logic [IDX_W-1:0]  k_q;
	logic [VAL_W-1:0]  diff_q;
	logic [PP_W-1:0]   pp_lo_s1;
	logic [PP_W-1:0]   pp_hi_s2;
	logic [BID_W-1:0]  bid_q;
	obfd_lookup_t      mode_q;
	logic [SUM_W-1:0]  cum_q;
	logic [FPROD_W-1:0] fprod_s1;
	logic [SUM_W-1:0]  win_q;
	logic signed [PRF_W-1:0] prof_q;
	logic              out_valid_q;

	logic              bin_ok;
	logic [SUM_W:0]    sum_ext;
	logic [SUM_W-1:0]  sum_sat;
	logic [VAL_W-1:0]  held_next;
	logic [VAL_W-1:0]  price;
	logic [BEST_W-1:0] profit;
	logic [IDX_W+MULT_W-1:0] bid_raw;
	logic [CNT_W-1:0]  top_cnt;
	logic [IDX_W-1:0]  top_idx;
	logic [BID_W-1:0]  max_bid;
	logic [IDX_W-1:0]  lo;
	logic [CNT_W-1:0]  lo_inc;
	logic [SUM_W-1:0]  nxt;
	logic [SUM_W:0]    win_ext;
	logic signed [DIFF_W-1:0]  diff2;
	logic signed [WPROD_W-1:0] wprod;

	assign bin_ok    = (cnt_q < CNT_W'(MAX_BINS));
	assign sum_ext   = {1'b0, sum_q} + (SUM_W+1)'(prob_bin);
	assign sum_sat   = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
	assign held_next = (cnt_q == '0) ? bid_value : held_q;
	assign price     = VAL_W'({cnt_q[IDX_W-1:0], 8'b0});
	assign profit    = {pp_hi_s2, {SPLIT_W{1'b0}}} + BEST_W'(pp_lo_s1);

	assign bid_raw = (IDX_W+MULT_W)'(best_idx_q) * (IDX_W+MULT_W)'(mult_q);
	assign top_cnt = cnt_q - CNT_W'(1);
	assign top_idx = top_cnt[IDX_W-1:0];
	assign max_bid = {top_idx, {FRAC_W{1'b0}}};
	assign lo      = bid_q[BID_W-1:FRAC_W];
	assign lo_inc  = {1'b0, lo} + CNT_W'(1);
	assign nxt     = rdata_q - cum_q;
	assign win_ext = {1'b0, cum_q} + (SUM_W+1)'(fprod_s1[FPROD_W-1:FRAC_W]);
	assign diff2   = $signed({1'b0, held_q, 4'b0}) - $signed(DIFF_W'(bid_q));
	assign wprod   = diff2 * $signed({1'b0, win_q});

	always_comb begin
		rd_addr = lo;
		if (cmd.rd0 && lo_inc >= cnt_q) begin
			rd_addr = top_idx;
		end else if (cmd.rd1) begin
			rd_addr = lo_inc[IDX_W-1:0];
		end
	end

	// prefix store, written on each counted bin, registered read port
	always_ff @(posedge clk) begin
		if (cmd.load && bin_ok) begin
			prefix_mem[cnt_q[IDX_W-1:0]] <= sum_sat;
		end
		rdata_q <= prefix_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_q      <= MULT_RESET;
			sum_q       <= '0;
			cnt_q       <= '0;
			held_q      <= '0;
			ovf_q       <= 1'b0;
			best_q      <= '0;
			best_idx_q  <= '0;
			last_q      <= 1'b0;
			bin_ok_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				mult_q <= strategy_multiplier;
			end
			if (cmd.load) begin
				last_q   <= last_bin;
				bin_ok_q <= bin_ok;
				if (bin_ok) begin
					sum_q  <= sum_sat;
					held_q <= held_next;
					cnt_q  <= cnt_q + CNT_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.cmp && bin_ok_q && (first_q || profit > best_q)) begin
				best_q     <= profit;
				best_idx_q <= k_q;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				sum_q       <= '0;
				cnt_q       <= '0;
				held_q      <= '0;
				ovf_q       <= 1'b0;
				best_q      <= '0;
				best_idx_q  <= '0;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			k_q     <= cnt_q[IDX_W-1:0];
			first_q <= (cnt_q == '0);
			diff_q  <= (price <= held_next) ? held_next - price : '0;
		end
		// profit = diff * sum, split into two partial products
		if (cmd.mul_lo) begin
			pp_lo_s1 <= PP_W'(diff_q) * PP_W'(sum_q[SPLIT_W-1:0]);
		end
		if (cmd.mul_hi) begin
			pp_hi_s2 <= PP_W'(diff_q) * PP_W'(sum_q[SUM_W-1:SPLIT_W]);
		end
		if (cmd.bid) begin
			bid_q <= (bid_raw > (IDX_W+MULT_W)'(max_bid)) ? max_bid : bid_raw[BID_W-1:0];
		end
		if (cmd.rd0) begin
			if (bid_q == '0) begin
				mode_q <= LK_ZERO;
			end else if (lo_inc >= cnt_q) begin
				mode_q <= LK_SINGLE;
			end else begin
				mode_q <= LK_INTERP;
			end
		end
		if (cmd.rd1) begin
			cum_q <= rdata_q;
		end
		if (cmd.interp) begin
			fprod_s1 <= FPROD_W'(bid_q[FRAC_W-1:0]) * FPROD_W'(nxt);
		end
		if (cmd.sum) begin
			unique case (mode_q)
				LK_ZERO:   win_q <= '0;
				LK_SINGLE: win_q <= cum_q;
				LK_INTERP: win_q <= win_ext[SUM_W] ? SUM_MAX : win_ext[SUM_W-1:0];
				default:   win_q <= '0;
			endcase
		end
		if (cmd.prof) begin
			// arithmetic shift floors toward minus infinity
			prof_q <= PRF_W'(wprod >>> PRF_SHIFT);
		end
		if (cmd.emit) begin
			shaded_bid      <= bid_q;
			win_prob_at_bid <= win_q;
			profit_est      <= prof_q;
			chosen_bin      <= BIN_W'(best_idx_q);
			too_many_bins   <= ovf_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign status.last     = last_q;
	assign status.out_free = !out_valid_q || out_ready;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_BINS))
		else $error("bin count beyond store depth");

	a_bid_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd0 |-> (cnt_q != '0 && bid_q <= max_bid))
		else $error("bid not clamped to the top bin of the run");

	a_run_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (cnt_q == '0 && sum_q == '0 && !ovf_q))
		else $error("run state not cleared after result");
`endif

endmodule

/* sim/optimal_bid_from_win_distribution_unit_tb.sv */
// testbench for optimal_bid_from_win_distribution_unit: streams runs of price bins,
// predicts the shaded bid of each run and checks every result transaction
// depends on obfd_pkg and the unit itself
module optimal_bid_from_win_distribution_unit_tb
	import obfd_pkg::*;
();

	localparam int DRAIN_CYCLES = 40;
	localparam int RUN_LIMIT    = 6000000;

	typedef enum int {
		MASS_RANDOM,
		MASS_ZERO,
		MASS_FULL,
		MASS_SMALL,
		MASS_MIXED
	} mass_kind_t;

	typedef struct {
		logic [BID_W-1:0]        bid;
		logic [SUM_W-1:0]        win;
		logic signed [PRF_W-1:0] profit;
		logic [BIN_W-1:0]        bin;
		logic                    over;
	} bid_result_t;

	class shaded_bid_tracker;
		bit [SUM_W-1:0]  cdf_mem [MAX_BINS];
		bit [MULT_W-1:0] mult = MULT_RESET;
		bit [SUM_W-1:0]  cum_mass;
		bit [63:0]       top_profit;
		bit [IDX_W-1:0]  top_idx;
		bit [CNT_W-1:0]  bins_in_run;
		bit [VAL_W-1:0]  value_held;
		bit              run_too_long;
		bid_result_t     pending_bids [$];
		int              mismatches;
		int              checked;

		function void clear_run();
			cum_mass     = '0;
			top_profit   = '0;
			top_idx      = '0;
			bins_in_run  = '0;
			value_held   = '0;
			run_too_long = 1'b0;
		endfunction

		function void set_multiplier(bit [MULT_W-1:0] m);
			mult = m;
		endfunction

		function int pending();
			return pending_bids.size();
		endfunction

		// cumulative probability at a Q.12 bid, linear between bins
		function bit [SUM_W-1:0] cdf_at(bit [63:0] bid, int unsigned n);
			bit [63:0] lo;
			bit [63:0] frac;
			bit [63:0] step;
			bit [63:0] v;
			if (bid == 0)
				return '0;
			lo = bid >> FRAC_W;
			if (lo + 1 >= n)
				return cdf_mem[n - 1];
			step = cdf_mem[lo + 1] - cdf_mem[lo];
			frac = bid[FRAC_W-1:0];
			v = cdf_mem[lo] + ((frac * step) >> FRAC_W);
			if (v > SUM_MAX)
				v = SUM_MAX;
			return v[SUM_W-1:0];
		endfunction

		function void take_bin(bit [PROB_W-1:0] mass, bit [VAL_W-1:0] value, bit last);
			int unsigned k;
			int unsigned n;
			bit [SUM_W:0] s;
			bit [63:0]    price;
			bit [63:0]    profit;
			bit [63:0]    bid;
			bit [63:0]    max_bid;
			bit [SUM_W-1:0] win;
			longint       diff;
			longint       prod;
			bid_result_t  r;
			if (bins_in_run >= MAX_BINS) begin
				run_too_long = 1'b1;
			end else begin
				k = bins_in_run;
				if (k == 0)
					value_held = value;
				s = cum_mass + mass;
				if (s > SUM_MAX)
					s = SUM_MAX;
				cum_mass = s[SUM_W-1:0];
				cdf_mem[k] = cum_mass;
				price = 64'(k) << 8;
				profit = '0;
				if (price <= value_held)
					profit = (64'(value_held) - price) * cum_mass;
				// ties keep the earliest bin
				if (k == 0 || profit > top_profit) begin
					top_profit = profit;
					top_idx = k[IDX_W-1:0];
				end
				bins_in_run = CNT_W'(k + 1);
			end
			if (!last)
				return;
			n = (bins_in_run == 0) ? 1 : bins_in_run;
			bid = 64'(top_idx) * 64'(mult);
			max_bid = 64'(n - 1) << FRAC_W;
			if (bid > max_bid)
				bid = max_bid;
			win = cdf_at(bid, n);
			diff = longint'({value_held, 4'b0000}) - longint'(bid);
			prod = diff * longint'(win);
			r.bid = bid[BID_W-1:0];
			r.win = win;
			r.profit = PRF_W'(prod >>> PRF_SHIFT);
			r.bin = top_idx;
			r.over = run_too_long;
			pending_bids.push_back(r);
			clear_run();
		endfunction

		function void compare_field(string name, longint exp, longint got);
			if (exp != got) begin
				$display("%0t: %s expected %0d got %0d", $time, name, exp, got);
				mismatches++;
			end
		endfunction

		function void check_bid(logic [BID_W-1:0] bid, logic [SUM_W-1:0] win,
				logic signed [PRF_W-1:0] profit, logic [BIN_W-1:0] bin, logic over);
			bid_result_t e;
			if (pending_bids.size() == 0) begin
				$display("%0t: result with none expected, bid %0d", $time, bid);
				mismatches++;
				return;
			end
			e = pending_bids.pop_front();
			checked++;
			compare_field("shaded_bid", longint'(e.bid), longint'(bid));
			compare_field("win_prob_at_bid", longint'(e.win), longint'(win));
			compare_field("profit_est", longint'(e.profit), longint'(profit));
			compare_field("chosen_bin", longint'(e.bin), longint'(bin));
			compare_field("too_many_bins", longint'(e.over), longint'(over));
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic [PROB_W-1:0]       prob_bin;
	logic [VAL_W-1:0]        bid_value;
	logic                    last_bin;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [MULT_W-1:0]       strategy_multiplier;
	logic                    out_valid;
	logic                    out_ready;
	logic [BID_W-1:0]        shaded_bid;
	logic [SUM_W-1:0]        win_prob_at_bid;
	logic signed [PRF_W-1:0] profit_est;
	logic [BIN_W-1:0]        chosen_bin;
	logic                    too_many_bins;

	shaded_bid_tracker tracker;
	bit gaps_on = 1'b1;
	int bins_sent;
	int runs_sent;
	int long_runs;

	optimal_bid_from_win_distribution_unit dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.prob_bin            (prob_bin),
		.bid_value           (bid_value),
		.last_bin            (last_bin),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.strategy_multiplier (strategy_multiplier),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.shaded_bid          (shaded_bid),
		.win_prob_at_bid     (win_prob_at_bid),
		.profit_est          (profit_est),
		.chosen_bin          (chosen_bin),
		.too_many_bins       (too_many_bins)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int draw_gap();
		int r;
		if (!gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [PROB_W-1:0] draw_mass(mass_kind_t kind);
		mass_kind_t k;
		k = kind;
		if (k == MASS_MIXED)
			k = mass_kind_t'($urandom_range(0, 3));
		case (k)
			MASS_ZERO:  return '0;
			MASS_FULL:  return '1;
			MASS_SMALL: return PROB_W'($urandom_range(0, 255));
			default:    return PROB_W'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic send_bin(input logic [PROB_W-1:0] mass, input logic [VAL_W-1:0] value,
			input logic last);
		int gap;
		gap = draw_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		prob_bin = mass;
		bid_value = value;
		last_bin = last;
		do @(posedge clk); while (!in_ready);
		tracker.take_bin(mass, value, last);
		bins_sent++;
	endtask

	// only the first bin's value counts, later bins carry noise there
	task automatic send_run(input int n, input logic [VAL_W-1:0] value, input mass_kind_t kind);
		for (int i = 0; i < n; i++)
			send_bin(draw_mass(kind), (i == 0) ? value : VAL_W'($urandom_range(0, 16777215)),
				i == n - 1);
		runs_sent++;
		if (n > MAX_BINS)
			long_runs++;
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic change_multiplier(input logic [MULT_W-1:0] m);
		settle();
		@(negedge clk);
		cfg_valid = 1'b1;
		strategy_multiplier = m;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_multiplier(m);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic random_phase(input int bin_goal);
		int stop_at;
		int n;
		int r;
		logic [VAL_W-1:0] value;
		stop_at = bins_sent + bin_goal;
		while (bins_sent < stop_at) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			r = $urandom_range(0, 99);
			if (r < 10)
				n = $urandom_range(1, 2);
			else if (r < 75)
				n = $urandom_range(3, 16);
			else if (r < 97)
				n = $urandom_range(17, 64);
			else
				n = $urandom_range(65, 300);
			r = $urandom_range(0, 99);
			if (r < 10)
				value = VAL_W'($urandom_range(0, 16777215));
			else if (r < 15)
				value = '0;
			else
				value = VAL_W'($urandom_range(0, n * 384));
			send_run(n, value, mass_kind_t'($urandom_range(0, 4)));
		end
	endtask

	// result side: random stalls on out_ready
	initial begin
		int hold;
		hold = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				out_ready = 1'b0;
				hold--;
			end else begin
				out_ready = 1'b1;
				hold = draw_gap();
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				tracker.check_bid(shaded_bid, win_prob_at_bid, profit_est,
					chosen_bin, too_many_bins);
		end
	end

	initial begin
		tracker = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		prob_bin = '0;
		bid_value = '0;
		last_bin = 1'b0;
		cfg_valid = 1'b0;
		strategy_multiplier = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: single-bin runs, zero mass, full mass, value of zero
		change_multiplier(MULT_RESET);
		send_run(1, 24'hFFFFFF, MASS_FULL);
		send_run(1, 24'h000000, MASS_ZERO);
		send_run(4, 24'h000380, MASS_RANDOM);
		send_run(3, 24'h000200, MASS_ZERO);
		send_run(3, 24'h000000, MASS_FULL);
		// zero multiplier forces a zero bid
		change_multiplier(16'h0000);
		send_run(3, 24'h000300, MASS_RANDOM);
		// largest multiplier clamps to the top bin
		change_multiplier(16'hFFFF);
		send_run(4, 24'hFFFFFF, MASS_SMALL);
		// 1.5 lands between bins
		change_multiplier(16'd6144);
		send_run(5, 24'h000400, MASS_MIXED);

		// one run fills the store and ends on a dropped bin
		change_multiplier(MULT_RESET);
		send_run(MAX_BINS + 3, 24'h030000, MASS_MIXED);

		change_multiplier(MULT_W'($urandom_range(0, 65535)));
		random_phase(180);
		change_multiplier(MULT_W'($urandom_range(2048, 8192)));
		random_phase(180);
		change_multiplier(MULT_RESET);
		random_phase(180);
		change_multiplier(MULT_W'($urandom_range(4096, 16384)));
		random_phase(180);
		settle();

		$display("covered %0d bins in %0d runs (%0d past the store depth), %0d results checked",
			bins_sent, runs_sent, long_runs, tracker.checked);
		$display("multipliers included zero, one and full scale, %0d mismatches",
			tracker.mismatches);
		if (tracker.mismatches == 0)
			$display("optimal_bid_from_win_distribution_unit_tb OK");
		else
			$display("optimal_bid_from_win_distribution_unit_tb NOT OK");
		$finish;
	end

	initial begin
		#RUN_LIMIT;
		$display("timeout with %0d results outstanding", tracker.pending());
		$display("optimal_bid_from_win_distribution_unit_tb NOT OK");
		$finish;
	end

endmodule
